FILE: rtl/core/pthc_pkg.sv
// ----------------------------------------------------------------------------
// pthc_pkg: shared types and micro-program for pressure/temperature/humidity
// Holds the micro-op format, operand codes and the micro-program ROM that the
// sequencer of the compensation block steps through.
// ----------------------------------------------------------------------------
package pthc_pkg;

    localparam int RAW_W   = 20;
    localparam int PC_W    = 7;
    localparam int SEL_W   = 6;
    localparam int SH_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 64;

    // Action / kind codes
    localparam logic [1:0] ACT_TEMP  = 2'd0;
    localparam logic [1:0] ACT_PRESS = 2'd1;
    localparam logic [1:0] ACT_HUM   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_T  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_PL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_PH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_P9 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_H  = 3'd4;

    // Program entry points
    localparam logic [PC_W-1:0] PC_TEMP   = 7'd0;
    localparam logic [PC_W-1:0] PC_PRESS  = 7'd16;
    localparam logic [PC_W-1:0] PC_P_END  = 7'd49;
    localparam logic [PC_W-1:0] PC_HUM    = 7'd56;
    localparam logic [PC_W-1:0] PC_NONE   = 7'd127;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    // Operand select codes
    localparam logic [SEL_W-1:0] SEL_R0 = 6'd0;
    localparam logic [SEL_W-1:0] SEL_R1 = 6'd1;
    localparam logic [SEL_W-1:0] SEL_R2 = 6'd2;
    localparam logic [SEL_W-1:0] SEL_R3 = 6'd3;
    localparam logic [SEL_W-1:0] SEL_RAW = 6'd4;
    localparam logic [SEL_W-1:0] SEL_T1 = 6'd5;
    localparam logic [SEL_W-1:0] SEL_T2 = 6'd6;
    localparam logic [SEL_W-1:0] SEL_T3 = 6'd7;
    localparam logic [SEL_W-1:0] SEL_P1 = 6'd8;
    localparam logic [SEL_W-1:0] SEL_P2 = 6'd9;
    localparam logic [SEL_W-1:0] SEL_P3 = 6'd10;
    localparam logic [SEL_W-1:0] SEL_P4 = 6'd11;
    localparam logic [SEL_W-1:0] SEL_P5 = 6'd12;
    localparam logic [SEL_W-1:0] SEL_P6 = 6'd13;
    localparam logic [SEL_W-1:0] SEL_P7 = 6'd14;
    localparam logic [SEL_W-1:0] SEL_P8 = 6'd15;
    localparam logic [SEL_W-1:0] SEL_P9 = 6'd16;
    localparam logic [SEL_W-1:0] SEL_H1 = 6'd17;
    localparam logic [SEL_W-1:0] SEL_H2 = 6'd18;
    localparam logic [SEL_W-1:0] SEL_H3 = 6'd19;
    localparam logic [SEL_W-1:0] SEL_H4 = 6'd20;
    localparam logic [SEL_W-1:0] SEL_H5 = 6'd21;
    localparam logic [SEL_W-1:0] SEL_H6 = 6'd22;
    localparam logic [SEL_W-1:0] SEL_FINE = 6'd23;
    localparam logic [SEL_W-1:0] SEL_K128000 = 6'd24;
    localparam logic [SEL_W-1:0] SEL_K1048576 = 6'd25;
    localparam logic [SEL_W-1:0] SEL_K3125 = 6'd26;
    localparam logic [SEL_W-1:0] SEL_K76800 = 6'd27;
    localparam logic [SEL_W-1:0] SEL_K16384 = 6'd28;
    localparam logic [SEL_W-1:0] SEL_K32768 = 6'd29;
    localparam logic [SEL_W-1:0] SEL_K2097152 = 6'd30;
    localparam logic [SEL_W-1:0] SEL_K8192 = 6'd31;
    localparam logic [SEL_W-1:0] SEL_K2P47 = 6'd32;
    localparam logic [SEL_W-1:0] SEL_K5 = 6'd33;
    localparam logic [SEL_W-1:0] SEL_K128 = 6'd34;
    localparam logic [SEL_W-1:0] SEL_NONE = 6'd35;

    typedef enum logic [2:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_ASR, ALU_SHL, ALU_DIV, ALU_BZ, ALU_END
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic             w32;   // wrap result to 32 bits, sign-extended
        logic             wf;    // also store result as fine temperature
        logic [1:0]       dst;
        logic [SEL_W-1:0] a;
        logic [SEL_W-1:0] b;
        logic [SH_W-1:0]  sh;
    } uop_t;

    function automatic uop_t mk(input alu_op_t op, input logic w32, input logic wf,
                                input logic [1:0] dst, input logic [SEL_W-1:0] a,
                                input logic [SEL_W-1:0] b, input logic [SH_W-1:0] sh);
        uop_t u;
        u.op = op; u.w32 = w32; u.wf = wf; u.dst = dst;
        u.a = a; u.b = b; u.sh = sh;
        return u;
    endfunction

    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        u = mk(ALU_END, 1'b0, 1'b0, 2'd0, SEL_NONE, SEL_NONE, 6'd0);
        case (pc)
            // temperature, 32-bit wrap
            7'd0:  u = mk(ALU_ASR, 1'b1, 1'b0, 2'd0, SEL_RAW, SEL_NONE, 6'd3);
            7'd1:  u = mk(ALU_SHL, 1'b1, 1'b0, 2'd1, SEL_T1, SEL_NONE, 6'd1);
            7'd2:  u = mk(ALU_SUB, 1'b1, 1'b0, 2'd0, SEL_R0, SEL_R1, 6'd0);
            7'd3:  u = mk(ALU_MUL, 1'b1, 1'b0, 2'd0, SEL_R0, SEL_T2, 6'd0);
            7'd4:  u = mk(ALU_ASR, 1'b1, 1'b0, 2'd0, SEL_R0, SEL_NONE, 6'd11);
            7'd5:  u = mk(ALU_ASR, 1'b1, 1'b0, 2'd1, SEL_RAW, SEL_NONE, 6'd4);
            7'd6:  u = mk(ALU_SUB, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_T1, 6'd0);
            7'd7:  u = mk(ALU_MUL, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_R1, 6'd0);
            7'd8:  u = mk(ALU_ASR, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_NONE, 6'd12);
            7'd9:  u = mk(ALU_MUL, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_T3, 6'd0);
            7'd10: u = mk(ALU_ASR, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_NONE, 6'd14);
            7'd11: u = mk(ALU_ADD, 1'b1, 1'b1, 2'd0, SEL_R0, SEL_R1, 6'd0);
            7'd12: u = mk(ALU_MUL, 1'b1, 1'b0, 2'd0, SEL_R0, SEL_K5, 6'd0);
            7'd13: u = mk(ALU_ADD, 1'b1, 1'b0, 2'd0, SEL_R0, SEL_K128, 6'd0);
            7'd14: u = mk(ALU_ASR, 1'b1, 1'b0, 2'd0, SEL_R0, SEL_NONE, 6'd8);
            // pressure, 64-bit wrap
            7'd16: u = mk(ALU_SUB, 1'b0, 1'b0, 2'd0, SEL_FINE, SEL_K128000, 6'd0);
            7'd17: u = mk(ALU_MUL, 1'b0, 1'b0, 2'd1, SEL_R0, SEL_R0, 6'd0);
            7'd18: u = mk(ALU_MUL, 1'b0, 1'b0, 2'd2, SEL_R1, SEL_P6, 6'd0);
            7'd19: u = mk(ALU_MUL, 1'b0, 1'b0, 2'd3, SEL_R0, SEL_P5, 6'd0);
            7'd20: u = mk(ALU_SHL, 1'b0, 1'b0, 2'd3, SEL_R3, SEL_NONE, 6'd17);
            7'd21: u = mk(ALU_ADD, 1'b0, 1'b0, 2'd2, SEL_R2, SEL_R3, 6'd0);
            7'd22: u = mk(ALU_SHL, 1'b0, 1'b0, 2'd3, SEL_P4, SEL_NONE, 6'd35);
            7'd23: u = mk(ALU_ADD, 1'b0, 1'b0, 2'd2, SEL_R2, SEL_R3, 6'd0);
            7'd24: u = mk(ALU_MUL, 1'b0, 1'b0, 2'd1, SEL_R1, SEL_P3, 6'd0);
            7'd25: u = mk(ALU_ASR, 1'b0, 1'b0, 2'd1, SEL_R1, SEL_NONE, 6'd8);
            7'd26: u = mk(ALU_MUL, 1'b0, 1'b0, 2'd3, SEL_R0, SEL_P2, 6'd0);
            7'd27: u = mk(ALU_SHL, 1'b0, 1'b0, 2'd3, SEL_R3, SEL_NONE, 6'd12);
            7'd28: u = mk(ALU_ADD, 1'b0, 1'b0, 2'd0, SEL_R1, SEL_R3, 6'd0);
            7'd29: u = mk(ALU_ADD, 1'b0, 1'b0, 2'd0, SEL_R0, SEL_K2P47, 6'd0);
            7'd30: u = mk(ALU_MUL, 1'b0, 1'b0, 2'd0, SEL_R0, SEL_P1, 6'd0);
            7'd31: u = mk(ALU_ASR, 1'b0, 1'b0, 2'd0, SEL_R0, SEL_NONE, 6'd33);
            7'd32: u = mk(ALU_BZ,  1'b0, 1'b0, 2'd1, SEL_R0, SEL_NONE, 6'd0);
            7'd33: u = mk(ALU_SUB, 1'b0, 1'b0, 2'd1, SEL_K1048576, SEL_RAW, 6'd0);
            7'd34: u = mk(ALU_SHL, 1'b0, 1'b0, 2'd1, SEL_R1, SEL_NONE, 6'd31);
            7'd35: u = mk(ALU_SUB, 1'b0, 1'b0, 2'd1, SEL_R1, SEL_R2, 6'd0);
            7'd36: u = mk(ALU_MUL, 1'b0, 1'b0, 2'd1, SEL_R1, SEL_K3125, 6'd0);
            7'd37: u = mk(ALU_DIV, 1'b0, 1'b0, 2'd1, SEL_R1, SEL_R0, 6'd0);
            7'd38: u = mk(ALU_ASR, 1'b0, 1'b0, 2'd2, SEL_R1, SEL_NONE, 6'd13);
            7'd39: u = mk(ALU_MUL, 1'b0, 1'b0, 2'd3, SEL_R2, SEL_R2, 6'd0);
            7'd40: u = mk(ALU_MUL, 1'b0, 1'b0, 2'd3, SEL_R3, SEL_P9, 6'd0);
            7'd41: u = mk(ALU_ASR, 1'b0, 1'b0, 2'd3, SEL_R3, SEL_NONE, 6'd25);
            7'd42: u = mk(ALU_MUL, 1'b0, 1'b0, 2'd2, SEL_R1, SEL_P8, 6'd0);
            7'd43: u = mk(ALU_ASR, 1'b0, 1'b0, 2'd2, SEL_R2, SEL_NONE, 6'd19);
            7'd44: u = mk(ALU_ADD, 1'b0, 1'b0, 2'd1, SEL_R1, SEL_R3, 6'd0);
            7'd45: u = mk(ALU_ADD, 1'b0, 1'b0, 2'd1, SEL_R1, SEL_R2, 6'd0);
            7'd46: u = mk(ALU_ASR, 1'b0, 1'b0, 2'd1, SEL_R1, SEL_NONE, 6'd8);
            7'd47: u = mk(ALU_SHL, 1'b0, 1'b0, 2'd3, SEL_P7, SEL_NONE, 6'd4);
            7'd48: u = mk(ALU_ADD, 1'b0, 1'b0, 2'd1, SEL_R1, SEL_R3, 6'd0);
            // humidity, 32-bit wrap
            7'd56: u = mk(ALU_SUB, 1'b1, 1'b0, 2'd0, SEL_FINE, SEL_K76800, 6'd0);
            7'd57: u = mk(ALU_SHL, 1'b1, 1'b0, 2'd1, SEL_RAW, SEL_NONE, 6'd14);
            7'd58: u = mk(ALU_SHL, 1'b1, 1'b0, 2'd2, SEL_H4, SEL_NONE, 6'd20);
            7'd59: u = mk(ALU_SUB, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_R2, 6'd0);
            7'd60: u = mk(ALU_MUL, 1'b1, 1'b0, 2'd2, SEL_H5, SEL_R0, 6'd0);
            7'd61: u = mk(ALU_SUB, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_R2, 6'd0);
            7'd62: u = mk(ALU_ADD, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_K16384, 6'd0);
            7'd63: u = mk(ALU_ASR, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_NONE, 6'd15);
            7'd64: u = mk(ALU_MUL, 1'b1, 1'b0, 2'd2, SEL_R0, SEL_H6, 6'd0);
            7'd65: u = mk(ALU_ASR, 1'b1, 1'b0, 2'd2, SEL_R2, SEL_NONE, 6'd10);
            7'd66: u = mk(ALU_MUL, 1'b1, 1'b0, 2'd3, SEL_R0, SEL_H3, 6'd0);
            7'd67: u = mk(ALU_ASR, 1'b1, 1'b0, 2'd3, SEL_R3, SEL_NONE, 6'd11);
            7'd68: u = mk(ALU_ADD, 1'b1, 1'b0, 2'd3, SEL_R3, SEL_K32768, 6'd0);
            7'd69: u = mk(ALU_MUL, 1'b1, 1'b0, 2'd2, SEL_R2, SEL_R3, 6'd0);
            7'd70: u = mk(ALU_ASR, 1'b1, 1'b0, 2'd2, SEL_R2, SEL_NONE, 6'd10);
            7'd71: u = mk(ALU_ADD, 1'b1, 1'b0, 2'd2, SEL_R2, SEL_K2097152, 6'd0);
            7'd72: u = mk(ALU_MUL, 1'b1, 1'b0, 2'd2, SEL_R2, SEL_H2, 6'd0);
            7'd73: u = mk(ALU_ADD, 1'b1, 1'b0, 2'd2, SEL_R2, SEL_K8192, 6'd0);
            7'd74: u = mk(ALU_ASR, 1'b1, 1'b0, 2'd2, SEL_R2, SEL_NONE, 6'd14);
            7'd75: u = mk(ALU_MUL, 1'b1, 1'b0, 2'd0, SEL_R1, SEL_R2, 6'd0);
            7'd76: u = mk(ALU_ASR, 1'b1, 1'b0, 2'd1, SEL_R0, SEL_NONE, 6'd15);
            7'd77: u = mk(ALU_MUL, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_R1, 6'd0);
            7'd78: u = mk(ALU_ASR, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_NONE, 6'd7);
            7'd79: u = mk(ALU_MUL, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_H1, 6'd0);
            7'd80: u = mk(ALU_ASR, 1'b1, 1'b0, 2'd1, SEL_R1, SEL_NONE, 6'd4);
            7'd81: u = mk(ALU_SUB, 1'b1, 1'b0, 2'd0, SEL_R0, SEL_R1, 6'd0);
            default: u = mk(ALU_END, 1'b0, 1'b0, 2'd0, SEL_NONE, SEL_NONE, 6'd0);
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/core/pth_sensor_compensation.sv
// ----------------------------------------------------------------------------
// pth_sensor_compensation: integer compensation of raw P/T/H readings
// A micro-programmed sequencer drives one shared ALU, a 32x32 multiplier used
// in three passes per 64-bit product, and a bit-serial 64-bit divider.
// ----------------------------------------------------------------------------
// Pressure runs 33 micro-ops, 10 of them products, and a divide; when the
//   divisor is zero the divide and the steps after it are skipped.
// Flow: one item at a time; s_tready is high only while the sequencer idles,
//   and a result waiting in the output register holds the end step.
// Reset: synchronous, active low; clears trims, fine temperature and control.
module pth_sensor_compensation (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // [19:0] raw_reading
    input  logic [1:0]   s_tuser,   // [1:0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // [31:0] temperature_centi, [63:32] pressure_q24_8,
                                    // [80:64] humidity_q7_10, [81] divide_guard
    output logic [1:0]   m_tuser,   // [1:0] kind
    input  logic         cfg_we,
    input  logic [pthc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pthc_pkg::CFG_W-1:0]     cfg_data
);
    import pthc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIV  = 4'b1000
    } state_t;

    state_t state_reg;

    // Trim registers
    logic [47:0] trim_t_reg;
    logic [63:0] trim_pl_reg, trim_ph_reg, trim_h_reg;
    logic [15:0] trim_p9_reg;
    logic [31:0] fine_reg;

    // Item context
    logic [RAW_W-1:0] raw_reg;
    logic [1:0]       kind_reg;
    logic [PC_W-1:0]  pc_reg;
    logic             guard_reg;
    logic [63:0]      rf_reg [4];

    // Shared multiplier and divider state
    logic [63:0] mul_a_reg, mul_b_reg, acc_reg;
    logic [1:0]  mcnt_reg;
    logic [63:0] quo_reg, rem_reg, dvs_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [31:0] out_temp_reg, out_press_reg;
    logic [16:0] out_hum_reg;
    logic        out_guard_reg;
    logic [1:0]  out_kind_reg;

    uop_t        uop;
    logic [63:0] opa, opb, alu_res, alu_w;
    logic [31:0] mx, my;
    logic [63:0] prod, mul_fin, mul_w;
    logic [64:0] div_shift, div_diff;
    logic [63:0] quo_fin;
    logic [31:0] hum_clamped;
    logic        out_free, finish;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] wrap(input logic w32, input logic [63:0] v);
        return w32 ? {{32{v[31]}}, v[31:0]} : v;
    endfunction

    function automatic logic [63:0] operand(input logic [SEL_W-1:0] sel);
        logic [63:0] v;
        v = '0;
        case (sel)
            SEL_R0:       v = rf_reg[0];
            SEL_R1:       v = rf_reg[1];
            SEL_R2:       v = rf_reg[2];
            SEL_R3:       v = rf_reg[3];
            SEL_RAW:      v = {{(64-RAW_W){1'b0}}, raw_reg};
            SEL_T1:       v = {48'd0, trim_t_reg[15:0]};
            SEL_T2:       v = sx16(trim_t_reg[31:16]);
            SEL_T3:       v = sx16(trim_t_reg[47:32]);
            SEL_P1:       v = {48'd0, trim_pl_reg[15:0]};
            SEL_P2:       v = sx16(trim_pl_reg[31:16]);
            SEL_P3:       v = sx16(trim_pl_reg[47:32]);
            SEL_P4:       v = sx16(trim_pl_reg[63:48]);
            SEL_P5:       v = sx16(trim_ph_reg[15:0]);
            SEL_P6:       v = sx16(trim_ph_reg[31:16]);
            SEL_P7:       v = sx16(trim_ph_reg[47:32]);
            SEL_P8:       v = sx16(trim_ph_reg[63:48]);
            SEL_P9:       v = sx16(trim_p9_reg);
            SEL_H1:       v = {56'd0, trim_h_reg[7:0]};
            SEL_H2:       v = sx16(trim_h_reg[23:8]);
            SEL_H3:       v = {56'd0, trim_h_reg[31:24]};
            SEL_H4:       v = {{52{trim_h_reg[43]}}, trim_h_reg[43:32]};
            SEL_H5:       v = {{52{trim_h_reg[55]}}, trim_h_reg[55:44]};
            SEL_H6:       v = {{56{trim_h_reg[63]}}, trim_h_reg[63:56]};
            SEL_FINE:     v = {{32{fine_reg[31]}}, fine_reg};
            SEL_K128000:  v = 64'd128000;
            SEL_K1048576: v = 64'd1048576;
            SEL_K3125:    v = 64'd3125;
            SEL_K76800:   v = 64'd76800;
            SEL_K16384:   v = 64'd16384;
            SEL_K32768:   v = 64'd32768;
            SEL_K2097152: v = 64'd2097152;
            SEL_K8192:    v = 64'd8192;
            SEL_K2P47:    v = 64'h0000_8000_0000_0000;
            SEL_K5:       v = 64'd5;
            SEL_K128:     v = 64'd128;
            default:      v = '0;
        endcase
        return v;
    endfunction

    // Decode the current micro-op and run the combinational ALU
    always_comb begin
        uop = uop_rom(pc_reg);
        opa = operand(uop.a);
        opb = operand(uop.b);
        unique case (uop.op)
            ALU_ADD: alu_res = opa + opb;
            ALU_SUB: alu_res = opa - opb;
            ALU_ASR: alu_res = $unsigned($signed(opa) >>> uop.sh);
            ALU_SHL: alu_res = opa << uop.sh;
            default: alu_res = '0;
        endcase
        alu_w = wrap(uop.w32, alu_res);
    end

    // Shared 32x32 multiplier: low*low, then the two cross terms into the top half
    always_comb begin
        unique case (mcnt_reg)
            2'd0:    begin mx = mul_a_reg[31:0];  my = mul_b_reg[31:0];  end
            2'd1:    begin mx = mul_a_reg[31:0];  my = mul_b_reg[63:32]; end
            default: begin mx = mul_a_reg[63:32]; my = mul_b_reg[31:0];  end
        endcase
        prod    = {32'd0, mx} * {32'd0, my};
        mul_fin = acc_reg + {prod[31:0], 32'd0};
        mul_w   = wrap(uop.w32, mul_fin);
    end

    // Restoring divider step on magnitudes
    always_comb begin
        div_shift = {rem_reg, quo_reg[63]};
        div_diff  = div_shift - {1'b0, dvs_reg};
        quo_fin   = dneg_reg ? (64'd0 - {quo_reg[62:0], ~div_diff[64]})
                             : {quo_reg[62:0], ~div_diff[64]};
    end

    // Humidity clamp to 0..HUM_MAX ahead of the final shift
    always_comb begin
        if (rf_reg[0][31]) begin
            hum_clamped = '0;
        end else if (rf_reg[0][31:0] > HUM_MAX) begin
            hum_clamped = HUM_MAX;
        end else begin
            hum_clamped = rf_reg[0][31:0];
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == S_EXEC) && (uop.op == ALU_END) && out_free;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trim_t_reg  <= '0;
            trim_pl_reg <= '0;
            trim_ph_reg <= '0;
            trim_p9_reg <= '0;
            trim_h_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TRIM_T:  trim_t_reg  <= cfg_data[47:0];
                REG_TRIM_PL: trim_pl_reg <= cfg_data;
                REG_TRIM_PH: trim_ph_reg <= cfg_data;
                REG_TRIM_P9: trim_p9_reg <= cfg_data[15:0];
                REG_TRIM_H:  trim_h_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pc_reg    <= PC_NONE;
            fine_reg  <= '0;
            guard_reg <= 1'b0;
            mcnt_reg  <= '0;
            dcnt_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg  <= s_tuser;
                        guard_reg <= 1'b0;
                        // humidity uses only the low 16 bits of the reading
                        raw_reg   <= (s_tuser == ACT_HUM) ? {4'd0, s_tdata[15:0]}
                                                          : s_tdata[RAW_W-1:0];
                        unique case (s_tuser)
                            ACT_TEMP:  pc_reg <= PC_TEMP;
                            ACT_PRESS: pc_reg <= PC_PRESS;
                            ACT_HUM:   pc_reg <= PC_HUM;
                            default:   pc_reg <= PC_NONE;
                        endcase
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (uop.op)
                        ALU_ADD, ALU_SUB, ALU_ASR, ALU_SHL: begin
                            rf_reg[uop.dst] <= alu_w;
                            if (uop.wf) begin
                                fine_reg <= alu_w[31:0];
                            end
                            pc_reg <= pc_reg + 1'b1;
                        end
                        ALU_MUL: begin
                            mul_a_reg <= opa;
                            mul_b_reg <= opb;
                            mcnt_reg  <= '0;
                            state_reg <= S_MUL;
                        end
                        ALU_DIV: begin
                            quo_reg   <= opa[63] ? 64'd0 - opa : opa;
                            dvs_reg   <= opb[63] ? 64'd0 - opb : opb;
                            dneg_reg  <= opa[63] ^ opb[63];
                            rem_reg   <= '0;
                            dcnt_reg  <= '0;
                            state_reg <= S_DIV;
                        end
                        ALU_BZ: begin
                            // zero divisor: force the result, flag it, skip ahead
                            if (opa == 64'd0) begin
                                rf_reg[uop.dst] <= '0;
                                guard_reg       <= 1'b1;
                                pc_reg          <= PC_P_END;
                            end else begin
                                pc_reg <= pc_reg + 1'b1;
                            end
                        end
                        ALU_END: begin
                            if (out_free) begin
                                state_reg <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_MUL: begin
                    if (mcnt_reg == 2'd0) begin
                        acc_reg  <= prod;
                        mcnt_reg <= 2'd1;
                    end else if (mcnt_reg == 2'd1) begin
                        acc_reg  <= mul_fin;
                        mcnt_reg <= 2'd2;
                    end else begin
                        rf_reg[uop.dst] <= mul_w;
                        mcnt_reg  <= '0;
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= S_EXEC;
                    end
                end
                S_DIV: begin
                    quo_reg <= {quo_reg[62:0], ~div_diff[64]};
                    rem_reg <= div_diff[64] ? div_shift[63:0] : div_diff[63:0];
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 6'd63) begin
                        rf_reg[uop.dst] <= quo_fin;
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= S_EXEC;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Output register: load on finish, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (finish) begin
            m_tvalid_reg  <= 1'b1;
            out_kind_reg  <= kind_reg;
            out_temp_reg  <= (kind_reg == ACT_TEMP)  ? rf_reg[0][31:0] : 32'd0;
            out_press_reg <= (kind_reg == ACT_PRESS) ? rf_reg[1][31:0] : 32'd0;
            out_hum_reg   <= (kind_reg == ACT_HUM)   ? hum_clamped[28:12] : 17'd0;
            out_guard_reg <= (kind_reg == ACT_PRESS) && guard_reg;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_guard_reg, out_hum_reg, out_press_reg, out_temp_reg};

    // Checks
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");
    a_guard_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_guard_reg |-> out_kind_reg == ACT_PRESS && out_press_reg == 32'd0)
        else $error("divide guard on a non-pressure or non-zero result");
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> out_hum_reg <= 17'd102400)
        else $error("humidity above full scale");
    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_MUL |-> mcnt_reg == 2'd0)
        else $error("multiplier pass count left over");

endmodule
